### rtl/lpcp_pkg.sv
// ---------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants for the lidar point camera projection core.
// ---------------------------------------------------------------------------
package lpcp_pkg;

    localparam int COORD_FRAC   = 12;
    localparam int ACC_W        = 64;
    localparam int REG_W        = 64;
    localparam int HALF_W       = 32;
    localparam int NUM_REGS     = 6;
    localparam int REG_PER_ROW  = 2;
    localparam int NUM_ROWS     = 3;
    localparam int REG_ADDR_W   = 6;
    localparam int REG_IDX_W    = 3;
    localparam int REG_IDX_LSB  = 3;

    localparam int AFF_LAT      = 4;
    localparam int DIV_QBITS    = 17;
    localparam int DIV_LAT      = DIV_QBITS + 2;
    localparam int TOT_LAT      = AFF_LAT + DIV_LAT;
    localparam int RNG_STEPS    = 16;
    localparam int SHADE_STEPS  = 8;
    localparam int RNG_LAT      = RNG_STEPS + 4;
    localparam int RNG_PAD      = TOT_LAT - RNG_LAT;

    localparam logic [DIV_QBITS-1:0] QUOT_POS_LIM = 17'd32767;
    localparam logic [DIV_QBITS-1:0] QUOT_NEG_LIM = 17'd32768;
    localparam logic signed [15:0]   PIX_MAX      = 16'sh7fff;
    localparam logic signed [15:0]   PIX_MIN      = 16'sh8000;

    localparam logic [63:0] FAR_LIM      = 64'd65025 << (2 * COORD_FRAC);
    localparam logic [15:0] RANGE_MAX    = 16'd65025;
    localparam logic [7:0]  SHADE_MAX    = 8'd255;
    localparam int          SHADE_SCALE  = 2500;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_reg_file;

    typedef struct packed {
        logic                  psel;
        logic                  penable;
        logic                  pwrite;
        logic [REG_ADDR_W-1:0] paddr;
        logic [REG_W-1:0]      pwdata;
    } t_apb_req;

endpackage

### rtl/lpcp_if.sv
// ---------------------------------------------------------------------------
// lpcp interfaces
// Point input channel and pixel result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lpcp_point_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface lpcp_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic signed [31:0] homog_w;
    logic               no_projection;
    logic [7:0]         proximity_shade;
    logic [15:0]        range_value;

    modport source (output valid, output pixel_u, output pixel_v, output homog_w,
                    output no_projection, output proximity_shade, output range_value,
                    input ready);
    modport sink (input valid, input pixel_u, input pixel_v, input homog_w,
                  input no_projection, input proximity_shade, input range_value,
                  output ready);
endinterface

### rtl/lpcp_regs.sv
// ---------------------------------------------------------------------------
// lpcp_regs
// APB register file holding the 3x4 projection matrix.
// ---------------------------------------------------------------------------
module lpcp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpcp_pkg::t_apb_req          i_apb,
    output logic [lpcp_pkg::REG_W-1:0]  o_prdata,
    output lpcp_pkg::t_reg_file         o_regs
);

    lpcp_pkg::t_reg_file                r_regs;
    logic [lpcp_pkg::REG_IDX_W-1:0]     w_idx;
    logic                               w_hit;

    assign w_idx = i_apb.paddr[lpcp_pkg::REG_IDX_LSB +: lpcp_pkg::REG_IDX_W];
    assign w_hit = w_idx < lpcp_pkg::REG_IDX_W'(lpcp_pkg::NUM_REGS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_apb.psel && i_apb.penable && i_apb.pwrite && w_hit) begin
            r_regs[w_idx] <= i_apb.pwdata;
        end
    end

    assign o_prdata = w_hit ? r_regs[w_idx] : '0;
    assign o_regs   = r_regs;

endmodule

### rtl/lpcp_affine.sv
// ---------------------------------------------------------------------------
// lpcp_affine
// Three row sums c0*x + c1*y + c2*z + c3*2^12, saturating 64-bit accumulate,
// four register stages.
// ---------------------------------------------------------------------------
module lpcp_affine #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [COORD_WIDTH-1:0]        i_x,
    input  logic signed [COORD_WIDTH-1:0]        i_y,
    input  logic signed [COORD_WIDTH-1:0]        i_z,
    input  lpcp_pkg::t_reg_file                  i_regs,
    output logic signed [lpcp_pkg::ACC_W-1:0]    o_sum [lpcp_pkg::NUM_ROWS]
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int AW = lpcp_pkg::ACC_W;

    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        return s[AW-1:0];
    endfunction

    for (genvar r = 0; r < lpcp_pkg::NUM_ROWS; r++) begin : g_row
        localparam int RA = lpcp_pkg::REG_PER_ROW * r;
        localparam int RC = lpcp_pkg::REG_PER_ROW * r + 1;
        localparam int HW = lpcp_pkg::HALF_W;

        logic signed [COEF_WIDTH-1:0] w_c0, w_c1, w_c2, w_c3;
        logic signed [PW-1:0]         r_p0, r_p1, r_p2, r_p2_d;
        logic signed [COEF_WIDTH-1:0] r_off, r_off_d, r_off_d2;
        logic signed [AW-1:0]         r_s1, r_s2, r_s3;

        assign w_c0 = i_regs[RA][COEF_WIDTH-1:0];
        assign w_c1 = i_regs[RA][HW +: COEF_WIDTH];
        assign w_c2 = i_regs[RC][COEF_WIDTH-1:0];
        assign w_c3 = i_regs[RC][HW +: COEF_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p0     <= PW'(w_c0) * PW'(i_x);
                r_p1     <= PW'(w_c1) * PW'(i_y);
                r_p2     <= PW'(w_c2) * PW'(i_z);
                r_off    <= w_c3;
                r_s1     <= sat_add(AW'(r_p0), AW'(r_p1));
                r_p2_d   <= r_p2;
                r_off_d  <= r_off;
                r_s2     <= sat_add(r_s1, AW'(r_p2_d));
                r_off_d2 <= r_off_d;
                r_s3     <= sat_add(r_s2, AW'(r_off_d2) <<< lpcp_pkg::COORD_FRAC);
            end
        end

        assign o_sum[r] = r_s3;
    end

endmodule

### rtl/lpcp_div.sv
// ---------------------------------------------------------------------------
// lpcp_div
// Pipelined signed divide, one quotient bit per stage, truncated toward zero
// and saturated to 16 bits.
// ---------------------------------------------------------------------------
module lpcp_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [lpcp_pkg::ACC_W-1:0] i_num,
    input  logic signed [lpcp_pkg::ACC_W-1:0] i_den,
    output logic signed [15:0]                o_quot
);

    localparam int QB = lpcp_pkg::DIV_QBITS;
    localparam int AW = lpcp_pkg::ACC_W;
    localparam int SW = AW + QB;

    logic [AW-1:0]  r_rem [0:QB];
    logic [AW-1:0]  r_ad  [0:QB];
    logic [QB-1:0]  r_q   [0:QB];
    logic           r_neg [0:QB];
    logic           r_ovf [0:QB];
    logic signed [15:0] r_quot;

    logic [AW-1:0]  w_an, w_ad;

    assign w_an = i_num[AW-1] ? AW'(~i_num + 1'b1) : AW'(i_num);
    assign w_ad = i_den[AW-1] ? AW'(~i_den + 1'b1) : AW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_an;
            r_ad[0]  <= w_ad;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[AW-1] ^ i_den[AW-1];
            r_ovf[0] <= {{QB{1'b0}}, w_an} >= {w_ad, {QB{1'b0}}};
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int B = QB - j;
        logic [SW-1:0] w_sh, w_rem;
        logic          w_ge;

        assign w_sh  = {{QB{1'b0}}, r_ad[j-1]} << B;
        assign w_rem = {{QB{1'b0}}, r_rem[j-1]};
        assign w_ge  = w_rem >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? AW'(w_rem - w_sh) : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (w_ge ? (QB'(1) << B) : '0);
                r_ad[j]  <= r_ad[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[QB]) begin
                r_quot <= (r_ovf[QB] || r_q[QB] > lpcp_pkg::QUOT_POS_LIM) ?
                          lpcp_pkg::PIX_MAX : 16'(r_q[QB]);
            end else begin
                r_quot <= (r_ovf[QB] || r_q[QB] > lpcp_pkg::QUOT_NEG_LIM) ?
                          lpcp_pkg::PIX_MIN : 16'(~r_q[QB] + 1'b1);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

### rtl/lpcp_range.sv
// ---------------------------------------------------------------------------
// lpcp_range
// Horizontal range value and proximity shade, bit-serial square root
// pipeline, one result bit per stage.
// ---------------------------------------------------------------------------
module lpcp_range #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    output logic [15:0]                   o_range,
    output logic [7:0]                    o_shade
);

    localparam int CW  = COORD_WIDTH;
    localparam int SQW = 2 * CW + 1;
    localparam int NS  = lpcp_pkg::RNG_STEPS;
    localparam int TS  = lpcp_pkg::SHADE_STEPS;
    localparam int FS  = 2 * lpcp_pkg::COORD_FRAC;

    logic [CW-1:0]    w_ax, w_ay;
    logic [2*CW-1:0]  r_x2, r_y2;
    logic [SQW-1:0]   w_sq;
    logic [39:0]      r_sq;
    logic             r_far2;
    logic [55:0]      w_m;

    logic [31:0]      r_b   [0:NS];
    logic [32:0]      r_a   [0:NS];
    logic [15:0]      r_k   [0:NS];
    logic [7:0]       r_t   [0:NS];
    logic             r_far [0:NS];
    logic [15:0]      r_range;
    logic [7:0]       r_shade;
    logic [7:0]       w_tc;

    assign w_ax = i_x[CW-1] ? CW'(~i_x + 1'b1) : CW'(i_x);
    assign w_ay = i_y[CW-1] ? CW'(~i_y + 1'b1) : CW'(i_y);
    assign w_sq = SQW'(r_x2) + SQW'(r_y2);
    // r^2 * 65025 = r^2 * (65536 - 512 + 1)
    assign w_m  = (56'(r_sq) << 16) - (56'(r_sq) << 9) + 56'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2     <= (2*CW)'(w_ax) * (2*CW)'(w_ax);
            r_y2     <= (2*CW)'(w_ay) * (2*CW)'(w_ay);
            r_sq     <= 40'(w_sq);
            r_far2   <= 66'(w_sq) >= 66'(lpcp_pkg::FAR_LIM);
            r_b[0]   <= w_m[55:FS];
            r_a[0]   <= 33'(w_m[55:FS]) + 33'(|w_m[FS-1:0]);
            r_k[0]   <= '0;
            r_t[0]   <= '0;
            r_far[0] <= r_far2;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_step
        localparam int KB = NS - j;
        logic [15:0] w_c;
        logic [7:0]  w_ct;
        logic        w_tk;

        assign w_c = r_k[j-1] | (16'(1) << KB);

        if (j <= TS) begin : g_shade
            localparam int TB = TS - j;
            logic [15:0] w_csq;
            logic [27:0] w_prod;
            assign w_ct   = r_t[j-1] | (8'(1) << TB);
            assign w_csq  = 16'(w_ct) * 16'(w_ct);
            assign w_prod = 28'(w_csq) * 28'(lpcp_pkg::SHADE_SCALE);
            assign w_tk   = 33'(w_prod) < r_a[j-1];
        end else begin : g_hold
            assign w_ct = r_t[j-1];
            assign w_tk = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[j]   <= (32'(w_c) * 32'(w_c) <= r_b[j-1]) ? w_c : r_k[j-1];
                r_t[j]   <= w_tk ? w_ct : r_t[j-1];
                r_b[j]   <= r_b[j-1];
                r_a[j]   <= r_a[j-1];
                r_far[j] <= r_far[j-1];
            end
        end
    end

    always_comb begin
        if (r_a[NS] == '0) begin
            w_tc = '0;
        end else if (r_t[NS] == lpcp_pkg::SHADE_MAX) begin
            w_tc = lpcp_pkg::SHADE_MAX;
        end else begin
            w_tc = r_t[NS] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_far[NS]) begin
                r_range <= lpcp_pkg::RANGE_MAX;
                r_shade <= '0;
            end else begin
                r_range <= (r_k[NS] > lpcp_pkg::RANGE_MAX) ? lpcp_pkg::RANGE_MAX : r_k[NS];
                r_shade <= lpcp_pkg::SHADE_MAX - w_tc;
            end
        end
    end

    assign o_range = r_range;
    assign o_shade = r_shade;

endmodule

### rtl/lidar_point_camera_projection_core.sv
// Throughput: one point per cycle; the whole pipeline holds while the
//   result register is full and not taken.
// Depth is set by the 19-stage divider (17 quotient bits plus input and
//   output registers) after the 4-stage row sums.
// Reset (synchronous, active low) clears valid bits and the matrix registers.
// ---------------------------------------------------------------------------
// lidar_point_camera_projection_core
// Projects a lidar point through a 3x4 matrix to pixel coordinates with
// range and shade depth cues.
// ---------------------------------------------------------------------------
module lidar_point_camera_projection_core #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lpcp_point_if.sink                         i_point,
    lpcp_pixel_if.source                       o_pixel,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpcp_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [lpcp_pkg::REG_W-1:0]         pwdata,
    output logic [lpcp_pkg::REG_W-1:0]         prdata,
    output logic                               pready
);

    localparam int TL = lpcp_pkg::TOT_LAT;
    localparam int DL = lpcp_pkg::DIV_LAT;
    localparam int PL = lpcp_pkg::RNG_PAD;
    localparam int AW = lpcp_pkg::ACC_W;

    lpcp_pkg::t_apb_req              w_apb;
    lpcp_pkg::t_reg_file             w_regs;
    logic                            w_en;
    logic [TL-1:0]                   r_vld;
    logic signed [COORD_WIDTH-1:0]   w_x, w_y, w_z;
    logic signed [AW-1:0]            w_sum [lpcp_pkg::NUM_ROWS];
    logic signed [AW-1:0]            w_wsh;
    logic signed [31:0]              w_wq;
    logic signed [15:0]              w_u, w_v;
    logic [15:0]                     w_range;
    logic [7:0]                      w_shade;
    logic signed [31:0]              r_wq [0:DL-1];
    logic                            r_wz [0:DL-1];
    logic [15:0]                     r_rng [0:PL-1];
    logic [7:0]                      r_shd [0:PL-1];

    assign w_apb  = '{psel: psel, penable: penable, pwrite: pwrite,
                      paddr: paddr, pwdata: pwdata};
    assign pready = 1'b1;

    lpcp_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apb    (w_apb),
        .o_prdata (prdata),
        .o_regs   (w_regs)
    );

    assign w_en          = !r_vld[TL-1] || o_pixel.ready;
    assign i_point.ready = w_en;
    assign w_x           = i_point.point_x;
    assign w_y           = i_point.point_y;
    assign w_z           = i_point.point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TL-2:0], i_point.valid};
        end
    end

    lpcp_affine #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_affine (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_x),
        .i_y    (w_y),
        .i_z    (w_z),
        .i_regs (w_regs),
        .o_sum  (w_sum)
    );

    lpcp_div u_div_u (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_sum[0]),
        .i_den  (w_sum[2]),
        .o_quot (w_u)
    );

    lpcp_div u_div_v (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_sum[1]),
        .i_den  (w_sum[2]),
        .o_quot (w_v)
    );

    lpcp_range #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_range (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_range (w_range),
        .o_shade (w_shade)
    );

    // Q.36 to Q8.24 by floor, saturated to 32 bits
    assign w_wsh = w_sum[2] >>> lpcp_pkg::COORD_FRAC;
    always_comb begin
        if ((&w_wsh[AW-1:31]) || !(|w_wsh[AW-1:31])) begin
            w_wq = w_wsh[31:0];
        end else begin
            w_wq = w_wsh[AW-1] ? 32'sh80000000 : 32'sh7fffffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wq[0]  <= w_wq;
            r_wz[0]  <= (w_sum[2] == '0);
            r_rng[0] <= w_range;
            r_shd[0] <= w_shade;
            for (int k = 1; k < DL; k++) begin
                r_wq[k] <= r_wq[k-1];
                r_wz[k] <= r_wz[k-1];
            end
            for (int k = 1; k < PL; k++) begin
                r_rng[k] <= r_rng[k-1];
                r_shd[k] <= r_shd[k-1];
            end
        end
    end

    assign o_pixel.valid           = r_vld[TL-1];
    assign o_pixel.pixel_u         = r_wz[DL-1] ? '0 : w_u;
    assign o_pixel.pixel_v         = r_wz[DL-1] ? '0 : w_v;
    assign o_pixel.homog_w         = r_wq[DL-1];
    assign o_pixel.no_projection   = r_wz[DL-1];
    assign o_pixel.proximity_shade = r_shd[PL-1];
    assign o_pixel.range_value     = r_rng[PL-1];

endmodule

### rtl/lpcp_checker.sv
// ---------------------------------------------------------------------------
// lpcp_checker
// Port-level checks on the projection core result channel.
// ---------------------------------------------------------------------------
module lpcp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_pixel_u,
    input logic signed [15:0] i_pixel_v,
    input logic               i_no_projection,
    input logic [7:0]         i_shade,
    input logic [15:0]        i_range
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pixel_u) && $stable(i_pixel_v))
        else $error("stalled result changed");

    a_no_proj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_projection |-> i_pixel_u == 16'sd0 && i_pixel_v == 16'sd0)
        else $error("pixel not zero on zero divisor");

    a_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_range == 16'd65025 |-> i_shade == 8'd0)
        else $error("far point with nonzero shade");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind lidar_point_camera_projection_core lpcp_checker u_lpcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_pixel.valid),
    .i_out_ready     (o_pixel.ready),
    .i_pixel_u       (o_pixel.pixel_u),
    .i_pixel_v       (o_pixel.pixel_v),
    .i_no_projection (o_pixel.no_projection),
    .i_shade         (o_pixel.proximity_shade),
    .i_range         (o_pixel.range_value)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar point camera projection core. Points go
// in over the valid/ready channel, the matrix is loaded over APB between
// phases, and every pixel item is checked field by field against an
// in-bench prediction of the projection, shade and range values.
// ---------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic signed [31:0] w;
        logic               np;
        logic [7:0]         shade;
        logic [15:0]        rng;
    } t_pixel;

    class projection_scoreboard;
        logic [63:0] matrix [lpcp_pkg::NUM_REGS];
        t_pixel      pixel_q[$];
        int          errors;

        function longint coef(int row, int k);
            logic [63:0] r;
            logic [31:0] h;
            r = matrix[row * 2 + k / 2];
            h = (k % 2) ? r[63:32] : r[31:0];
            return longint'(signed'(h));
        endfunction

        function longint sat_add(longint a, longint b);
            longint s;
            s = a + b;
            if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
                return (a < 0) ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
            return s;
        endfunction

        function longint row_sum(int row, longint x, longint y, longint z);
            longint s;
            s = coef(row, 0) * x;
            s = sat_add(s, coef(row, 1) * y);
            s = sat_add(s, coef(row, 2) * z);
            s = sat_add(s, coef(row, 3) * 64'sd4096);
            return s;
        endfunction

        function longint unsigned mag(longint a);
            return (a < 0) ? (64'd0 - a) : a;
        endfunction

        function logic signed [15:0] quot16(longint num, longint den);
            longint unsigned q;
            q = mag(num) / mag(den);
            if ((num < 0) == (den < 0))
                return (q > 32767) ? lpcp_pkg::PIX_MAX : 16'(q);
            return (q > 32768) ? lpcp_pkg::PIX_MIN : -16'(q);
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_point(logic signed [23:0] px, logic signed [23:0] py,
                                 logic signed [23:0] pz);
            longint x, y, z, s0, s1, w, wq;
            longint unsigned sq, q, t, den;
            t_pixel e;
            x = px;
            y = py;
            z = pz;
            s0 = row_sum(0, x, y, z);
            s1 = row_sum(1, x, y, z);
            w = row_sum(2, x, y, z);
            if (w == 0) begin
                e.u = 0;
                e.v = 0;
                e.np = 1;
            end else begin
                e.u = quot16(s0, w);
                e.v = quot16(s1, w);
                e.np = 0;
            end
            wq = w >>> 12;
            if (wq > 64'sd2147483647) wq = 64'sd2147483647;
            if (wq < -64'sd2147483648) wq = -64'sd2147483648;
            e.w = 32'(wq);
            sq = mag(x) * mag(x) + mag(y) * mag(y);
            if (sq >= lpcp_pkg::FAR_LIM) begin
                e.shade = 0;
                e.rng = lpcp_pkg::RANGE_MAX;
            end else begin
                q = isqrt((64'd65025 * sq) >> 24);
                e.rng = (q > 65025) ? lpcp_pkg::RANGE_MAX : 16'(q);
                den = 64'd2500 << 24;
                q = (64'd65025 * sq + den - 1) / den;
                t = isqrt(q);
                if (t * t < q) t++;
                if (t > 255) t = 255;
                e.shade = 8'(255 - t);
            end
            pixel_q.insert(pixel_q.size(), e);
        endfunction

        function void check_pixel(t_pixel a);
            t_pixel e;
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel item");
                errors++;
                return;
            end
            e = pixel_q.pop_front();
            if (a.u !== e.u) begin
                $error("pixel_u exp %0d got %0d", e.u, a.u); errors++;
            end
            if (a.v !== e.v) begin
                $error("pixel_v exp %0d got %0d", e.v, a.v); errors++;
            end
            if (a.w !== e.w) begin
                $error("homog_w exp %0d got %0d", e.w, a.w); errors++;
            end
            if (a.np !== e.np) begin
                $error("no_projection exp %0d got %0d", e.np, a.np); errors++;
            end
            if (a.shade !== e.shade) begin
                $error("proximity_shade exp %0d got %0d", e.shade, a.shade); errors++;
            end
            if (a.rng !== e.rng) begin
                $error("range_value exp %0d got %0d", e.rng, a.rng); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [lpcp_pkg::REG_ADDR_W-1:0] paddr;
    logic [lpcp_pkg::REG_W-1:0] pwdata, prdata;
    logic pready;

    lpcp_point_if #(.COORD_WIDTH(24)) pt_if ();
    lpcp_pixel_if px_if ();

    lidar_point_camera_projection_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (pt_if.sink),
        .o_pixel (px_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    projection_scoreboard sb = new();
    bit quiet;
    int hold_req, hold_seen, hold_left;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // result side: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        t_pixel a;
        if (!i_rst_n) begin
            px_if.ready <= 1'b0;
        end else begin
            if (px_if.valid && px_if.ready) begin
                a.u = px_if.pixel_u;
                a.v = px_if.pixel_v;
                a.w = px_if.homog_w;
                a.np = px_if.no_projection;
                a.shade = px_if.proximity_shade;
                a.rng = px_if.range_value;
                sb.check_pixel(a);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                px_if.ready <= 1'b0;
            end else begin
                px_if.ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    task automatic reg_write(int idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lpcp_pkg::REG_ADDR_W'(idx * 8);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx < lpcp_pkg::NUM_REGS) sb.matrix[idx] = val;
    endtask

    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z);
        while (!quiet && $urandom_range(99) < 8) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.point_z <= z;
        do @(posedge i_clk); while (!pt_if.ready);
        sb.note_point(x, y, z);
    endtask

    function automatic logic signed [23:0] rand_coord();
        int m;
        m = $urandom_range(9);
        if (m < 5) return 24'($signed($urandom_range(819200)) - 409600);
        if (m < 8) return 24'($urandom);
        if (m == 8) return 24'($signed($urandom_range(64)) - 32);
        return ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
    endfunction

    task automatic drain();
        pt_if.valid <= 1'b0;
        wait (sb.pixel_q.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_points(int n);
        repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic directed_points();
        send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_point(24'sh800000, 24'sh800000, 24'sh800000);
        send_point(24'sh7fffff, 24'sh800000, 24'sh000000);
        send_point(24'sd0, 24'sd0, 24'sd0);
        send_point(24'sd1, 24'sd0, -24'sd1);
        send_point(24'sd204800, 24'sd0, 24'sd4096);
        send_point(24'sd204799, 24'sd0, -24'sd4096);
        send_point(24'sd1044480, 24'sd0, 24'sd100);
        send_point(24'sd1044479, 24'sd1, 24'sd100);
        send_point(24'sd700000, 24'sd800000, 24'sd0);
        send_point(-24'sd40960, 24'sd81920, 24'sd8192);
    endtask

    function automatic logic [63:0] rand_reg();
        return {$urandom, $urandom};
    endfunction

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        quiet = 1'b0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) sb.matrix[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset matrix: w is zero everywhere
        directed_points();
        drain();

        // camera-like matrix scaled into Q8.24, looking down +x
        reg_write(0, {32'(-64'sd1468006400), 32'sd1342177280});
        reg_write(1, {32'sd0, 32'sd0});
        reg_write(2, {32'sd0, 32'sd754974720});
        reg_write(3, {32'sd16777216, 32'(-64'sd1468006400)});
        reg_write(4, {32'sd0, 32'sd2097152});
        reg_write(5, {32'sd0, 32'sd0});
        reg_write(6, rand_reg());
        directed_points();
        hold_req++;
        random_points(120);
        drain();
        random_points(160);
        drain();

        // small divisor: w equals x in Q.36
        reg_write(4, {32'sd0, 32'sd1});
        reg_write(5, {32'sd0, 32'sd0});
        repeat (120) send_point(24'($signed($urandom_range(16)) - 8), rand_coord(),
                                rand_coord());
        drain();

        // extremes of the coefficients with no idling on either side, then all-ones with random idling
        quiet = 1'b1;
        for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) reg_write(i, 64'h7fffffff7fffffff);
        directed_points();
        random_points(100);
        drain();
        for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) reg_write(i, 64'h8000000080000000);
        random_points(100);
        drain();
        quiet = 1'b0;
        for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) reg_write(i, 64'hffffffffffffffff);
        random_points(80);
        drain();

        // fully random matrices
        repeat (6) begin
            for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) reg_write(i, rand_reg());
            random_points(100);
            drain();
        end
        hold_req++;
        random_points(80);

        drain();
        if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

### sim.f
rtl/lpcp_pkg.sv
rtl/lpcp_if.sv
rtl/lpcp_regs.sv
rtl/lpcp_affine.sv
rtl/lpcp_div.sv
rtl/lpcp_range.sv
rtl/lidar_point_camera_projection_core.sv
rtl/lpcp_checker.sv
test/tb_top.sv
